>>> rtl/dlcf_pkg.sv
// shared types, constants and helpers of the dust low complexity filter
`timescale 1ns / 1ps

package dlcf_pkg;

	localparam int MAX_READ_LEN_DEF = 1024;
	localparam int RES_DEPTH_DEF    = 8;

	localparam int TRIMER_BINS = 125;
	localparam int BIN_IDX_W   = 7;
	localparam int CODE_W      = 3;
	localparam int Q_SHIFT     = 8;

	localparam int THR_W     = 18;
	localparam int MINLEN_W  = 11;
	localparam int LEN_OUT_W = 11;
	localparam int SUM_OUT_W = 19;

	localparam logic [CODE_W-1:0]   BASE_N        = 3'd4;
	localparam logic [MINLEN_W-1:0] MIN_LEN_FLOOR = 11'd5;
	localparam logic [THR_W-1:0]    THR_RESET     = 18'd1024;
	localparam logic [MINLEN_W-1:0] MINLEN_RESET  = 11'd5;

	localparam logic REG_SCORE_THRESHOLD = 1'b0;
	localparam logic REG_MIN_READ_LENGTH = 1'b1;

	typedef struct packed {
		logic                 dusted;
		logic                 undersized;
		logic                 too_long;
		logic [LEN_OUT_W-1:0] base_len;
		logic [SUM_OUT_W-1:0] pair_sum;
	} verdict_t;

	typedef struct packed {
		logic     valid;
		verdict_t data;
	} fifo_push_t;

	// bin of a trimer, codes already limited to 0..4
	function automatic logic [BIN_IDX_W-1:0] trimer_index(
		input logic [CODE_W-1:0] older,
		input logic [CODE_W-1:0] newer,
		input logic [CODE_W-1:0] code
	);
		trimer_index = BIN_IDX_W'(older) * 7'd25 + BIN_IDX_W'(newer) * 7'd5
			+ BIN_IDX_W'(code);
	endfunction

endpackage

>>> rtl/dlcf_if.sv
// request channels of the filter: base stream in, verdict stream out
`timescale 1ns / 1ps

interface dlcf_base_if;
	logic       valid;
	logic       ready;
	logic [2:0] nucleotide;
	logic       last_base;

	modport source (output valid, output nucleotide, output last_base, input ready);
	modport sink   (input valid, input nucleotide, input last_base, output ready);
endinterface

interface dlcf_verdict_if;
	logic        valid;
	logic        ready;
	logic        dusted;
	logic        undersized;
	logic        too_long;
	logic [10:0] base_len;
	logic [18:0] pair_sum;

	modport source (output valid, output dusted, output undersized, output too_long,
		output base_len, output pair_sum, input ready);
	modport sink   (input valid, input dusted, input undersized, input too_long,
		input base_len, input pair_sum, output ready);
endinterface

>>> rtl/dlcf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dlcf_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 125
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/dlcf_result_fifo.sv
// verdict queue between the scoring pipeline and the output channel
`timescale 1ns / 1ps

module dlcf_result_fifo #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dlcf_pkg::fifo_push_t       push,
	output logic [$clog2(DEPTH+1)-1:0] level,
	dlcf_verdict_if.source             verdicts
);

	import dlcf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	verdict_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	assign pop            = verdicts.valid && verdicts.ready;
	assign level          = level_q;
	assign verdicts.valid = (level_q != '0);

	assign verdicts.dusted     = mem_q[rd_ptr_q].dusted;
	assign verdicts.undersized = mem_q[rd_ptr_q].undersized;
	assign verdicts.too_long   = mem_q[rd_ptr_q].too_long;
	assign verdicts.base_len   = mem_q[rd_ptr_q].base_len;
	assign verdicts.pair_sum   = mem_q[rd_ptr_q].pair_sum;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push.valid) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/dust_low_complexity_filter.sv
// dust triplet low complexity filter: one base per cycle in while ready is high, one verdict per read out
// a read's verdict passes the registered stages 1, 2 and 3, then the verdict queue, after its last base is accepted
// throughput: one base per cycle while ready is high, set by the single histogram ram read-modify-write
// ready drops only while queued plus in-flight verdicts fill the RES_DEPTH queue
// reset: asynchronous; histogram bins are flagged empty at once, no clearing pass
`timescale 1ns / 1ps

module dust_low_complexity_filter #(
	parameter int MAX_READ_LEN = dlcf_pkg::MAX_READ_LEN_DEF,
	parameter int RES_DEPTH    = dlcf_pkg::RES_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	dlcf_base_if.sink       bases,
	dlcf_verdict_if.source  verdicts
);

	import dlcf_pkg::*;

	// base counter holds MAX_READ_LEN itself; a bin never exceeds MAX_READ_LEN - 2
	localparam int CNT_W     = $clog2(MAX_READ_LEN + 1);
	localparam int BIN_W     = $clog2(MAX_READ_LEN);
	localparam int SUM_W     = 2 * BIN_W;
	localparam int RHS_W     = THR_W + CNT_W;
	localparam int LHS_W     = SUM_W + Q_SHIFT;
	localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int LEN_CMP_W = (CNT_W > MINLEN_W) ? CNT_W : MINLEN_W;
	localparam int LVL_W     = $clog2(RES_DEPTH + 1);
	localparam int OCC_W     = $clog2(RES_DEPTH + 4);

	// configuration registers
	logic [THR_W-1:0]    thr_q;
	logic [MINLEN_W-1:0] min_len_q;
	logic                cfg_wr;

	// per-read running state
	logic [CNT_W-1:0]    base_cnt_q;
	logic [2*CODE_W-1:0] prev_q;
	logic                ovf_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TRIMER_BINS-1:0] bin_valid_q;

	// accept stage
	logic                 accept;
	logic [CODE_W-1:0]    code_c;
	logic                 full_c;
	logic                 count_en_c;
	logic [CNT_W-1:0]     bc_next_c;
	logic                 ovf_next_c;
	logic [BIN_IDX_W-1:0] idx_c;

	// stage 1: histogram read data back, update and write
	logic                 vld_s1;
	logic                 last_s1;
	logic                 cnt_en_s1;
	logic [BIN_IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0]     len_s1;
	logic                 long_s1;
	logic [BIN_W-1:0]     ram_rdata;
	logic [BIN_W-1:0]     old_c;
	logic [BIN_W-1:0]     new_c;
	logic [SUM_W-1:0]     sum_next_c;
	logic                 we_c;
	logic [MINLEN_W-1:0]  eff_min_c;
	logic                 short_c;

	// forwarding of the write made in the previous cycle
	logic                 wr_en_q;
	logic [BIN_IDX_W-1:0] wr_idx_q;
	logic [BIN_W-1:0]     wr_cnt_q;
	logic                 fwd_hit_c;

	// stage 2: threshold product
	logic             vld_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [CNT_W-1:0] len_s2;
	logic             short_s2;
	logic             long_s2;
	logic [CNT_W-1:0] len_diff_c;
	logic [RHS_W-1:0] rhs_c;

	// stage 3: score compare into the verdict queue
	logic             vld_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [CNT_W-1:0] len_s3;
	logic             short_s3;
	logic             long_s3;
	logic [RHS_W-1:0] rhs_s3;
	logic [CMP_W-1:0] lhs_c;
	logic             low_cplx_c;

	fifo_push_t       push_c;
	logic [LVL_W-1:0] level;
	logic [OCC_W-1:0] occ_c;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register index sits in paddr[2], byte offset bits are ignored
	always_comb begin
		unique case (paddr[2])
			REG_SCORE_THRESHOLD: prdata = 32'(thr_q);
			REG_MIN_READ_LENGTH: prdata = 32'(min_len_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			min_len_q <= MINLEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SCORE_THRESHOLD: thr_q     <= pwdata[THR_W-1:0];
				REG_MIN_READ_LENGTH: min_len_q <= pwdata[MINLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- accept stage ----------------
	// room is reserved for every verdict that could still arrive, so the
	// pipeline itself never stalls and ready has no path from verdicts.ready
	assign occ_c = OCC_W'(level) + OCC_W'(vld_s1 && last_s1) + OCC_W'(vld_s2)
		+ OCC_W'(vld_s3);
	assign bases.ready = (occ_c < OCC_W'(RES_DEPTH));
	assign accept      = bases.valid && bases.ready;

	// unknown codes count as n
	assign code_c     = (bases.nucleotide > BASE_N) ? BASE_N : bases.nucleotide;
	assign full_c     = (base_cnt_q == CNT_W'(MAX_READ_LEN));
	assign count_en_c = !full_c && (base_cnt_q >= CNT_W'(2));
	assign bc_next_c  = full_c ? base_cnt_q : base_cnt_q + 1'b1;
	assign ovf_next_c = ovf_q || full_c;
	assign idx_c      = trimer_index(prev_q[2*CODE_W-1:CODE_W], prev_q[CODE_W-1:0], code_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cnt_q <= '0;
			prev_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (bases.last_base) begin
				base_cnt_q <= '0;
				prev_q     <= '0;
				ovf_q      <= 1'b0;
			end else begin
				base_cnt_q <= bc_next_c;
				ovf_q      <= ovf_next_c;
				if (!full_c) begin
					prev_q <= {prev_q[CODE_W-1:0], code_c};
				end
			end
		end
	end

	// ---------------- histogram ram ----------------
	// read is issued with the accepted base, data lands with it in stage 1
	dlcf_ram #(
		.WIDTH (BIN_W),
		.DEPTH (TRIMER_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (idx_s1),
		.wdata (new_c),
		.raddr (idx_c),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= bases.last_base;
			cnt_en_s1 <= count_en_c;
			idx_s1    <= idx_c;
			len_s1    <= bc_next_c;
			long_s1   <= ovf_next_c;
		end
	end

	// ---------------- stage 1 ----------------
	// the ram misses only the write of the cycle before; an empty bin reads zero
	assign fwd_hit_c  = wr_en_q && (wr_idx_q == idx_s1);
	assign old_c      = fwd_hit_c ? wr_cnt_q :
		(bin_valid_q[idx_s1] ? ram_rdata : '0);
	assign new_c      = old_c + 1'b1;
	assign we_c       = vld_s1 && cnt_en_s1;
	assign sum_next_c = sum_q + (cnt_en_s1 ? SUM_W'(old_c) : '0);

	assign eff_min_c = (min_len_q < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_q;
	assign short_c   = (LEN_CMP_W'(len_s1) < LEN_CMP_W'(eff_min_c));

	// end of read clears every bin valid flag and the pair sum together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			wr_en_q     <= 1'b0;
			sum_q       <= '0;
		end else begin
			wr_en_q <= we_c && !last_s1;
			if (vld_s1 && last_s1) begin
				bin_valid_q <= '0;
				sum_q       <= '0;
			end else begin
				if (we_c) begin
					bin_valid_q[idx_s1] <= 1'b1;
				end
				if (vld_s1) begin
					sum_q <= sum_next_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_q <= idx_s1;
		wr_cnt_q <= new_c;
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && last_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && last_s1) begin
			sum_s2   <= sum_next_c;
			len_s2   <= len_s1;
			short_s2 <= short_c;
			long_s2  <= long_s1;
		end
	end

	// trimer count is len - 2; wraps only for short reads, whose score is unused
	assign len_diff_c = len_s2 - CNT_W'(2);
	assign rhs_c      = RHS_W'(thr_q) * RHS_W'(len_diff_c);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			sum_s3   <= sum_s2;
			len_s3   <= len_s2;
			short_s3 <= short_s2;
			long_s3  <= long_s2;
			rhs_s3   <= rhs_c;
		end
	end

	// ---------------- stage 3 ----------------
	assign lhs_c      = CMP_W'(sum_s3) << Q_SHIFT;
	assign low_cplx_c = (lhs_c >= CMP_W'(rhs_s3));

	always_comb begin
		push_c.valid           = vld_s3;
		push_c.data.dusted     = short_s3 || long_s3 || low_cplx_c;
		push_c.data.undersized = short_s3;
		push_c.data.too_long   = long_s3;
		push_c.data.base_len   = LEN_OUT_W'(len_s3);
		push_c.data.pair_sum   = SUM_OUT_W'(sum_s3);
	end

	dlcf_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_c),
		.level    (level),
		.verdicts (verdicts)
	);

`ifndef ASSERT_OFF
	// queued plus in-flight verdicts never exceed the queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		occ_c <= OCC_W'(RES_DEPTH))
		else $error("verdict queue overrun");

	// a forwarded count always belongs to a bin already marked as filled
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_q |-> bin_valid_q[wr_idx_q])
		else $error("forwarded bin not marked valid");

	// the histogram is empty after every verdict leaves stage 1
	a_hist_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && last_s1) |=> (bin_valid_q == '0) && (sum_q == '0))
		else $error("histogram not cleared at end of read");

	// read state restarts after the last base
	a_read_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bases.last_base) |=> (base_cnt_q == '0) && !ovf_q)
		else $error("read state not restarted");
`endif

endmodule

>>> tb/sv/dust_low_complexity_filter_check.sv
// verdict checker: tracks register writes, predicts each read verdict and compares
`timescale 1ns / 1ps

module dust_low_complexity_filter_check #(
	parameter int READ_CAP = dlcf_pkg::MAX_READ_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	dlcf_base_if        bases,
	dlcf_verdict_if     verdicts,
	output int          failures,
	output int          verdicts_seen,
	output int          dusted_seen
);
	import dlcf_pkg::*;

	// predictor copy of the read state and the registers
	int unsigned       trimer_hist [TRIMER_BINS];
	logic [5:0]        recent_codes;
	int                base_total;
	longint unsigned   pairs;
	bit                overrun;
	logic [THR_W-1:0]    threshold_q8;
	logic [MINLEN_W-1:0] len_floor_cfg;

	verdict_t pending_verdicts[$];
	int       mismatch_count;
	int       unmatched_count;

	assign failures = mismatch_count + unmatched_count;

	task automatic start_read();
		foreach (trimer_hist[i])
			trimer_hist[i] = 0;
		recent_codes = '0;
		base_total   = 0;
		pairs        = 0;
		overrun      = 1'b0;
	endtask

	// one base of the stream; a closing base queues the expected verdict
	task automatic absorb_base(input logic [2:0] raw, input logic last);
		logic [2:0]          code;
		int                  bin;
		logic [MINLEN_W-1:0] floor_len;
		bit                  short_read;
		verdict_t            v;
		code = (raw > BASE_N) ? BASE_N : raw;
		if (base_total >= READ_CAP) begin
			overrun = 1'b1;
		end else begin
			if (base_total >= 2) begin
				bin = int'(recent_codes[5:3]) * 25 + int'(recent_codes[2:0]) * 5 + int'(code);
				pairs += trimer_hist[bin];
				trimer_hist[bin]++;
			end
			recent_codes = {recent_codes[2:0], code};
			base_total++;
		end
		if (last) begin
			floor_len  = (len_floor_cfg < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : len_floor_cfg;
			short_read = base_total < int'(floor_len);
			v.undersized = short_read;
			v.too_long   = overrun;
			v.base_len   = LEN_OUT_W'(base_total);
			v.pair_sum   = SUM_OUT_W'(pairs);
			if (short_read || overrun)
				v.dusted = 1'b1;
			else
				v.dusted = (pairs << Q_SHIFT) >=
					longint'(threshold_q8) * longint'(base_total - 2);
			pending_verdicts.push_back(v);
			start_read();
		end
	endtask

	task automatic compare_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_verdict();
		verdict_t want;
		verdict_t got;
		got.dusted     = verdicts.dusted;
		got.undersized = verdicts.undersized;
		got.too_long   = verdicts.too_long;
		got.base_len   = verdicts.base_len;
		got.pair_sum   = verdicts.pair_sum;
		if (pending_verdicts.size() == 0) begin
			$display("%0t: verdict with none expected, got %b/%b/%b length %0d pair_sum %0d",
				$time, got.dusted, got.undersized, got.too_long, got.base_len,
				got.pair_sum);
			mismatch_count++;
		end else begin
			want = pending_verdicts.pop_front();
			compare_field("dusted", want.dusted, got.dusted);
			compare_field("undersized", want.undersized, got.undersized);
			compare_field("too_long", want.too_long, got.too_long);
			compare_field("base_len", want.base_len, got.base_len);
			compare_field("pair_sum", want.pair_sum, got.pair_sum);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_read();
			threshold_q8  = THR_RESET;
			len_floor_cfg = MINLEN_RESET;
			pending_verdicts.delete();
			verdicts_seen <= 0;
			dusted_seen   <= 0;
		end else begin
			if (verdicts.valid && verdicts.ready) begin
				check_verdict();
				verdicts_seen <= verdicts_seen + 1;
				if (verdicts.dusted)
					dusted_seen <= dusted_seen + 1;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SCORE_THRESHOLD)
					threshold_q8 = pwdata[THR_W-1:0];
				else if (paddr[2] == REG_MIN_READ_LENGTH)
					len_floor_cfg = pwdata[MINLEN_W-1:0];
			end
			if (bases.valid && bases.ready)
				absorb_base(bases.nucleotide, bases.last_base);
		end
		unmatched_count <= pending_verdicts.size();
	end

endmodule

>>> tb/sv/dust_low_complexity_filter_test.sv
// testbench top: read stimulus, register settings and final verdict for the dust filter
`timescale 1ns / 1ps

module dust_low_complexity_filter_test;
	import dlcf_pkg::*;

	localparam int READ_CAP      = MAX_READ_LEN_DEF;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 2;
	localparam int PHASE_BASES   = 40;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dlcf_base_if    base_ch ();
	dlcf_verdict_if verdict_ch ();

	int failures;
	int verdicts_seen;
	int dusted_seen;
	int bases_sent;
	int reads_sent;
	int settings_used;
	int min_now;

	// both set by the stimulus; hold_verdicts is cleared by the receiver once its long hold-off is over
	bit steady_sender;
	bit hold_verdicts;

	// bases of the read about to be sent
	logic [2:0] read_codes[$];

	dust_low_complexity_filter #(
		.MAX_READ_LEN (READ_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.bases    (base_ch),
		.verdicts (verdict_ch)
	);

	dust_low_complexity_filter_check #(
		.READ_CAP (READ_CAP)
	) i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.bases         (base_ch),
		.verdicts      (verdict_ch),
		.failures      (failures),
		.verdicts_seen (verdicts_seen),
		.dusted_seen   (dusted_seen)
	);

	always #5 clk = ~clk;

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("dust_low_complexity_filter regression: fail");
		$finish;
	end

	// pause after an accepted base request: mostly none, now and then a long one
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// verdict back-pressure: short stalls mostly, a few long ones
	function automatic int stall_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// base code, with the unknown codes above N showing up now and then
	function automatic logic [2:0] pick_code();
		if ($urandom_range(0, 9) == 0)
			return 3'($urandom_range(5, 7));
		return 3'($urandom_range(0, 4));
	endfunction

	// receiver: random ready, with one long hold-off on request of the stimulus
	initial begin
		verdict_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_verdicts) begin
				verdict_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_verdicts = 1'b0;
			end else if ($urandom_range(0, 99) < 55) begin
				verdict_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				verdict_ch.ready <= 1'b0;
				repeat (stall_length()) @(posedge clk);
			end
		end
	end

	// offer one base and hold it until the filter takes it
	task automatic offer_base(input logic [2:0] code, input logic last);
		int gap;
		base_ch.valid      <= 1'b1;
		base_ch.nucleotide <= code;
		base_ch.last_base  <= last;
		do
			@(posedge clk);
		while (!base_ch.ready);
		bases_sent++;
		if (last)
			reads_sent++;
		gap = steady_sender ? 0 : sender_gap();
		if (gap > 0) begin
			base_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_read();
		foreach (read_codes[i])
			offer_base(read_codes[i], i == read_codes.size() - 1);
	endtask

	task automatic fill_run(input logic [2:0] code, input int len);
		read_codes.delete();
		repeat (len) read_codes.push_back(code);
	endtask

	task automatic fill_uniform(input int len);
		read_codes.delete();
		repeat (len) read_codes.push_back(pick_code());
	endtask

	// short motif repeated over the read, with the odd point change
	task automatic fill_repeat(input int len, input int period);
		logic [2:0] motif[$];
		logic [2:0] c;
		read_codes.delete();
		repeat (period) motif.push_back(pick_code());
		for (int i = 0; i < len; i++) begin
			c = motif[i % period];
			if ($urandom_range(0, 19) == 0)
				c = pick_code();
			read_codes.push_back(c);
		end
	endtask

	// register write: setup cycle, then access cycle until pready
	task automatic program_reg(input logic sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (sel == REG_MIN_READ_LENGTH)
			min_now = int'(value[MINLEN_W-1:0]);
	endtask

	task automatic apply_settings(input int threshold, input int min_len);
		program_reg(REG_SCORE_THRESHOLD, 32'(threshold));
		program_reg(REG_MIN_READ_LENGTH, 32'(min_len));
		settings_used++;
	endtask

	// stop offering, let every verdict come back, then give the pipe time to drain
	task automatic settle();
		base_ch.valid <= 1'b0;
		wait (verdicts_seen == reads_sent);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_settings();
		int r;
		int threshold;
		int min_len;
		r = $urandom_range(0, 99);
		threshold = (r < 70) ? $urandom_range(0, 3000) : $urandom_range(0, 262143);
		r = $urandom_range(0, 99);
		if (r < 60)
			min_len = $urandom_range(0, 40);
		else if (r < 90)
			min_len = $urandom_range(0, 200);
		else
			min_len = $urandom_range(0, 2047);
		apply_settings(threshold, min_len);
	endtask

	// one random read: mostly moderate lengths, some short, some around the minimum
	task automatic random_read();
		int r;
		int len;
		int floor_len;
		r = $urandom_range(0, 99);
		floor_len = (min_now < 5) ? 5 : min_now;
		if (r < 10)
			len = $urandom_range(1, 4);
		else if (r < 70)
			len = $urandom_range(5, 30);
		else if (r < 90)
			len = $urandom_range(31, 120);
		else if (floor_len <= 200)
			len = $urandom_range(floor_len - 1, floor_len + 1);
		else
			len = $urandom_range(5, 30);
		if ($urandom_range(0, 1))
			fill_repeat(len, $urandom_range(1, 4));
		else
			fill_uniform(len);
		send_read();
	endtask

	initial begin
		int phase_bases;
		int phase_reads;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		base_ch.valid      = 1'b0;
		base_ch.nucleotide = '0;
		base_ch.last_base  = 1'b0;
		min_now            = int'(MINLEN_RESET);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 4.0, minimum length 5
		fill_run(3'd0, 1);               // single base read, too short
		send_read();
		read_codes = '{3'd7, 3'd6, 3'd5, 3'd3};  // unknown codes, one short of the minimum
		send_read();
		fill_run(3'd0, 5);               // shortest scored read
		send_read();
		fill_run(3'd0, 10);              // score just under 4.0
		send_read();
		fill_run(3'd0, 11);              // score exactly 4.0, dusted on equality
		send_read();
		read_codes = '{3'd4, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5};  // unknown codes fold into N
		send_read();
		read_codes = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2};  // only the first trimer repeats
		send_read();
		settle();

		// zero threshold dusts every scored read; minimum below the floor acts as 5
		apply_settings(0, 0);
		fill_uniform(5);
		send_read();
		fill_uniform(4);
		send_read();
		settle();
		apply_settings(0, 4);
		fill_uniform(4);
		send_read();
		fill_repeat(9, 2);
		send_read();
		settle();

		// top threshold, minimum at the read cap: overlong single-trimer read, extra bases dropped,
		// carries the largest pair sum and a saturated length
		apply_settings(262143, READ_CAP);
		fill_run(3'd0, READ_CAP + 2);
		send_read();
		settle();
		apply_settings(262143, 2047);    // nothing can reach this minimum
		fill_repeat(12, 3);
		send_read();
		settle();

		// random phases, each under fresh register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_settings();
			phase_bases = bases_sent;
			phase_reads = reads_sent;
			if (p == 1) begin
				// receiver holds off while short reads keep coming, until the
				// verdict queue fills and base requests back up
				hold_verdicts = 1'b1;
				steady_sender = 1'b1;
				repeat (30) begin
					fill_uniform($urandom_range(5, 7));
					send_read();
				end
				steady_sender = 1'b0;
			end
			while (bases_sent - phase_bases < PHASE_BASES || reads_sent - phase_reads < 3)
				random_read();
			settle();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d bases in %0d reads under %0d register settings,",
			bases_sent, reads_sent, settings_used + 1);
		$display("with an overlong read; %0d verdicts compared, %0d dusted",
			verdicts_seen, dusted_seen);
		if (failures == 0)
			$display("dust_low_complexity_filter regression: pass");
		else
			$display("dust_low_complexity_filter regression: fail");
		$finish;
	end

endmodule
